// File: design/pcef_pkg.sv
// ----------------------------------------------------------------------------
// pcef_pkg
// Shared field widths, command codes, register indexes and result type for
// the precedence conflict edge finder.
// ----------------------------------------------------------------------------
package pcef_pkg;

	localparam int ACTION_W    = 3;
	localparam int INDEX_W     = 8;
	localparam int WEIGHT_W    = 16;
	localparam int CAP_W       = 32;
	localparam int COUNT_W     = 9;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	typedef logic [ACTION_W-1:0]    action_t;
	typedef logic [INDEX_W-1:0]     index_t;
	typedef logic [WEIGHT_W-1:0]    weight_t;
	typedef logic [CAP_W-1:0]       cap_t;
	typedef logic [COUNT_W-1:0]     count_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam action_t ACT_WEIGHT  = 3'd0;
	localparam action_t ACT_EDGE    = 3'd1;
	localparam action_t ACT_SEP     = 3'd2;
	localparam action_t ACT_TOPO    = 3'd3;
	localparam action_t ACT_COMPUTE = 3'd4;
	localparam action_t ACT_FETCH   = 3'd5;

	localparam cfg_index_t CFG_CAPACITY   = 1'b0;
	localparam cfg_index_t CFG_ITEM_COUNT = 1'b1;

	typedef struct packed {
		logic   exhausted;
		index_t first_item;
		index_t second_item;
	} res_t;

endpackage

// File: design/precedence_conflict_edge_finder.sv
// ----------------------------------------------------------------------------
// precedence_conflict_edge_finder
// Top level: request/result handshakes, configuration registers and the
// result register around the bitset sequencer.
// ----------------------------------------------------------------------------
// After reset the successor and separation stores are swept to zero over
// their whole address space, one word a cycle; no request is taken during
// the sweep. Weight and topological-position requests are written straight
// from the idle state, edge and separation requests pass through split, read
// and modify-write states. Compute first writes every descendant and ancestor
// word over the same address space, then ORs closure words with a read and a
// write per word and sets each ancestor bit on the walk with a read and a
// write; fetch splits, reads and checks each pair tested and walks every bit
// of each reachability interval summed. A finished result sits in an output
// register, so loads are taken while it waits.
// ----------------------------------------------------------------------------
module precedence_conflict_edge_finder #(
	parameter int MAX_ITEMS = 256,
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  pcef_pkg::cfg_index_t  cfg_index,
	input  pcef_pkg::cfg_data_t   cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pcef_pkg::action_t     action,
	input  pcef_pkg::index_t      index_a,
	input  pcef_pkg::index_t      index_b,
	input  pcef_pkg::weight_t     weight,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pcef_pkg::index_t      first_item,
	output pcef_pkg::index_t      second_item,
	output logic                  exhausted
);
	import pcef_pkg::*;

	cap_t   capacity_q;
	count_t item_count_q;
	logic   out_valid_q;
	res_t   out_q;
	logic   res_valid;
	res_t   res;
	logic   res_ok;

	assign res_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			item_count_q <= COUNT_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CAPACITY:   capacity_q <= cfg_data;
				CFG_ITEM_COUNT: item_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
			out_q <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	pcef_ctrl #(.MAX_ITEMS(MAX_ITEMS), .WORD_BITS(WORD_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(in_valid),
		.req_ready(in_ready),
		.action(action),
		.index_a(index_a),
		.index_b(index_b),
		.weight(weight),
		.capacity(capacity_q),
		.item_count(item_count_q),
		.res_ok(res_ok),
		.res_valid(res_valid),
		.res(res)
	);

	assign out_valid = out_valid_q;
	assign first_item = out_q.first_item;
	assign second_item = out_q.second_item;
	assign exhausted = out_q.exhausted;

endmodule

// File: design/pcef_ram.sv
// ----------------------------------------------------------------------------
// pcef_ram
// Synchronous memory, one write port and two read ports, registered reads.
// ----------------------------------------------------------------------------
module pcef_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [DATA_W-1:0] rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// File: design/pcef_ctrl.sv
// ----------------------------------------------------------------------------
// pcef_ctrl
// Sequencer and bitset stores: load read-modify-write, closure build and
// conflict pair scan.
// ----------------------------------------------------------------------------
module pcef_ctrl #(
	parameter int MAX_ITEMS = 256,
	parameter int WORD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  pcef_pkg::action_t action,
	input  pcef_pkg::index_t  index_a,
	input  pcef_pkg::index_t  index_b,
	input  pcef_pkg::weight_t weight,
	input  pcef_pkg::cap_t    capacity,
	input  pcef_pkg::count_t  item_count,
	input  logic             res_ok,
	output logic             res_valid,
	output pcef_pkg::res_t    res
);
	import pcef_pkg::*;

	localparam int IW        = $clog2(MAX_ITEMS);
	localparam int CW        = $clog2(MAX_ITEMS + 1);
	localparam int BW        = $clog2(WORD_BITS);
	localparam int ROW_WORDS = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
	localparam int RW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int ADDR_W    = IW + RW;
	localparam int SUMW      = WEIGHT_W + CW;
	localparam int DIV_S     = CW + BW;
	localparam int DIV_M     = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
	localparam int PW        = CW + DIV_S + 1;

	localparam logic [4:0] ST_CLEAR   = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_LD_SPL  = 5'd2;
	localparam logic [4:0] ST_LD_RD   = 5'd3;
	localparam logic [4:0] ST_LD_WR   = 5'd4;
	localparam logic [4:0] ST_CI      = 5'd5;
	localparam logic [4:0] ST_CT_RD   = 5'd6;
	localparam logic [4:0] ST_CT_CHK  = 5'd7;
	localparam logic [4:0] ST_CS_RD   = 5'd8;
	localparam logic [4:0] ST_CS_LD   = 5'd9;
	localparam logic [4:0] ST_CS_BIT  = 5'd10;
	localparam logic [4:0] ST_CO_RD   = 5'd11;
	localparam logic [4:0] ST_CO_WR   = 5'd12;
	localparam logic [4:0] ST_CA_RD   = 5'd13;
	localparam logic [4:0] ST_CA_LD   = 5'd14;
	localparam logic [4:0] ST_CA_BIT  = 5'd15;
	localparam logic [4:0] ST_CA_SRD  = 5'd16;
	localparam logic [4:0] ST_CA_SWR  = 5'd17;
	localparam logic [4:0] ST_F_START = 5'd18;
	localparam logic [4:0] ST_F_PAIR  = 5'd19;
	localparam logic [4:0] ST_F_RD    = 5'd20;
	localparam logic [4:0] ST_F_CHK   = 5'd21;
	localparam logic [4:0] ST_O_RD    = 5'd22;
	localparam logic [4:0] ST_O_LD    = 5'd23;
	localparam logic [4:0] ST_O_BIT   = 5'd24;
	localparam logic [4:0] ST_O_ADD   = 5'd25;
	localparam logic [4:0] ST_O_END   = 5'd26;
	localparam logic [4:0] ST_F_FOUND = 5'd27;
	localparam logic [4:0] ST_F_EXH   = 5'd28;

	function automatic logic [RW-1:0] f_word(input logic [CW-1:0] x);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(DIV_M);
		return RW'(p >> DIV_S);
	endfunction

	logic [4:0]           state_q;
	logic [ADDR_W-1:0]    clr_q;
	action_t              act_q;
	index_t               a_q;
	index_t               b_q;
	logic [RW-1:0]        word_q;
	logic [BW-1:0]        bit_q;
	logic [CW-1:0]        k_q;
	logic [IW-1:0]        from_q;
	logic [RW-1:0]        wd_q;
	logic [BW-1:0]        sb_q;
	logic [CW-1:0]        j_q;
	logic [RW-1:0]        dw_q;
	logic [WORD_BITS-1:0] row_q;
	logic [CW-1:0]        i_q;
	logic [RW-1:0]        diag_w_q;
	logic [BW-1:0]        diag_b_q;
	logic [CW-1:0]        lhs_q;
	logic [IW-1:0]        rhs_q;
	logic [CW-1:0]        fa_q;
	logic [CW-1:0]        fb_q;
	logic [RW-1:0]        wa_q;
	logic [RW-1:0]        wb_q;
	logic [BW-1:0]        ba_q;
	logic [BW-1:0]        bb_q;
	logic [IW-1:0]        ofrom_q;
	logic [IW-1:0]        oto_q;
	logic [SUMW-1:0]      sum_q;
	logic                 pend_q;

	logic [CW-1:0]        n;
	logic                 a_ok;
	logic                 b_ok;
	logic                 adv_wrap;
	logic [ADDR_W-1:0]    ld_addr;
	logic [IW-1:0]        ci_row;
	logic [RW-1:0]        ci_word;

	logic                 s_we, p_we, d_we, an_we, w_we, t_we;
	logic [ADDR_W-1:0]    s_wa, p_wa, d_wa, an_wa;
	logic [WORD_BITS-1:0] s_wd, p_wd, d_wd, an_wd;
	logic [ADDR_W-1:0]    s_ra, p_raa, p_rab, d_raa, d_rab, an_ra;
	logic [WORD_BITS-1:0] s_rd, p_rda, p_rdb, d_rda, d_rdb, an_rd;
	logic [IW-1:0]        w_wa, w_ra, t_wa, t_ra;
	weight_t              w_wd, w_rd;
	index_t               t_wd, t_rd;

	assign n = (16'(item_count) > 16'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(item_count);
	assign a_ok = 16'(index_a) < 16'(MAX_ITEMS);
	assign b_ok = 16'(index_b) < 16'(MAX_ITEMS);
	assign adv_wrap = (sb_q == BW'(WORD_BITS - 1));
	assign ld_addr = {IW'(a_q), word_q};
	assign ci_row = clr_q[ADDR_W-1:RW];
	assign ci_word = clr_q[RW-1:0];
	assign req_ready = (state_q == ST_IDLE);

	assign res_valid = ((state_q == ST_F_FOUND) || (state_q == ST_F_EXH)) && res_ok;
	assign res.exhausted = (state_q == ST_F_EXH);
	assign res.first_item = (state_q == ST_F_EXH) ? '0 : INDEX_W'(fa_q);
	assign res.second_item = (state_q == ST_F_EXH) ? '0 : INDEX_W'(fb_q);

	always_comb begin
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
		p_we = 1'b0; p_wa = '0; p_wd = '0; p_raa = '0; p_rab = '0;
		d_we = 1'b0; d_wa = '0; d_wd = '0; d_raa = '0; d_rab = '0;
		an_we = 1'b0; an_wa = '0; an_wd = '0; an_ra = '0;
		w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
		unique case (state_q)
			ST_CLEAR: begin
				s_we = 1'b1; s_wa = clr_q;
				p_we = 1'b1; p_wa = clr_q;
			end
			ST_IDLE: begin
				if (req_valid && a_ok && action == ACT_WEIGHT) begin
					w_we = 1'b1; w_wa = IW'(index_a); w_wd = weight;
				end
				if (req_valid && a_ok && action == ACT_TOPO) begin
					t_we = 1'b1; t_wa = IW'(index_a); t_wd = index_b;
				end
			end
			ST_LD_RD: begin
				s_ra = ld_addr;
				p_raa = ld_addr;
			end
			ST_LD_WR: begin
				if (act_q == ACT_EDGE) begin
					s_we = 1'b1; s_wa = ld_addr;
					s_wd = s_rd | (WORD_BITS'(1) << bit_q);
				end else begin
					p_we = 1'b1; p_wa = ld_addr;
					p_wd = p_rda | (WORD_BITS'(1) << bit_q);
				end
			end
			ST_CI: begin
				d_we = 1'b1; d_wa = clr_q;
				if ((CW'(ci_row) < n) && (ci_word == diag_w_q)) begin
					d_wd = WORD_BITS'(1) << diag_b_q;
				end
				an_we = 1'b1; an_wa = clr_q;
			end
			ST_CT_RD: t_ra = IW'(k_q - CW'(1));
			ST_CS_RD: s_ra = {from_q, wd_q};
			ST_CO_RD: begin
				d_raa = {IW'(j_q), dw_q};
				d_rab = {from_q, dw_q};
			end
			ST_CO_WR: begin
				d_we = 1'b1; d_wa = {from_q, dw_q}; d_wd = d_rda | d_rdb;
			end
			ST_CA_RD: d_raa = {IW'(i_q), wd_q};
			ST_CA_SRD: an_ra = {IW'(j_q), diag_w_q};
			ST_CA_SWR: begin
				an_we = 1'b1; an_wa = {IW'(j_q), diag_w_q};
				an_wd = an_rd | (WORD_BITS'(1) << diag_b_q);
			end
			ST_F_RD: begin
				p_raa = {IW'(fa_q), wb_q};
				p_rab = {IW'(fb_q), wa_q};
				d_raa = {IW'(fa_q), wb_q};
				d_rab = {IW'(fb_q), wa_q};
			end
			ST_O_RD: begin
				d_raa = {ofrom_q, wd_q};
				an_ra = {oto_q, wd_q};
			end
			ST_O_BIT: begin
				if (j_q < n && row_q[sb_q]) begin
					w_ra = IW'(j_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			act_q <= '0; a_q <= '0; b_q <= '0;
			word_q <= '0; bit_q <= '0;
			k_q <= '0; from_q <= '0; wd_q <= '0; sb_q <= '0; j_q <= '0; dw_q <= '0;
			row_q <= '0; i_q <= '0; diag_w_q <= '0; diag_b_q <= '0;
			lhs_q <= '0; rhs_q <= '0; fa_q <= '0; fb_q <= '0;
			wa_q <= '0; wb_q <= '0; ba_q <= '0; bb_q <= '0;
			ofrom_q <= '0; oto_q <= '0; sum_q <= '0; pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						act_q <= action;
						a_q <= index_a;
						b_q <= index_b;
						case (action) inside
							ACT_EDGE, ACT_SEP: begin
								if (a_ok && b_ok) begin
									state_q <= ST_LD_SPL;
								end
							end
							ACT_COMPUTE: begin
								clr_q <= '0;
								diag_w_q <= '0;
								diag_b_q <= '0;
								state_q <= ST_CI;
							end
							ACT_FETCH: state_q <= ST_F_START;
							default: ;
						endcase
					end
				end
				ST_LD_SPL: begin
					word_q <= f_word(CW'(b_q));
					state_q <= ST_LD_RD;
				end
				ST_LD_RD: begin
					bit_q <= BW'(16'(b_q) - 16'(word_q) * 16'(WORD_BITS));
					state_q <= ST_LD_WR;
				end
				ST_LD_WR: state_q <= ST_IDLE;
				ST_CI: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (ci_word == '1) begin
						if (diag_b_q == BW'(WORD_BITS - 1)) begin
							diag_b_q <= '0;
							diag_w_q <= diag_w_q + RW'(1);
						end else begin
							diag_b_q <= diag_b_q + BW'(1);
						end
					end
					if (clr_q == '1) begin
						if (n == '0) begin
							lhs_q <= '0; rhs_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= n;
							state_q <= ST_CT_RD;
						end
					end
				end
				ST_CT_RD: state_q <= ST_CT_CHK;
				ST_CT_CHK: begin
					if (16'(t_rd) >= 16'(n)) begin
						k_q <= k_q - CW'(1);
						if (k_q == CW'(1)) begin
							i_q <= '0; wd_q <= '0; sb_q <= '0; j_q <= '0;
							diag_w_q <= '0; diag_b_q <= '0;
							state_q <= ST_CA_RD;
						end else begin
							state_q <= ST_CT_RD;
						end
					end else begin
						from_q <= IW'(t_rd);
						wd_q <= '0; sb_q <= '0; j_q <= '0;
						state_q <= ST_CS_RD;
					end
				end
				ST_CS_RD: state_q <= ST_CS_LD;
				ST_CS_LD: begin
					row_q <= s_rd;
					state_q <= ST_CS_BIT;
				end
				ST_CS_BIT: begin
					if (j_q >= n) begin
						k_q <= k_q - CW'(1);
						if (k_q == CW'(1)) begin
							i_q <= '0; wd_q <= '0; sb_q <= '0; j_q <= '0;
							diag_w_q <= '0; diag_b_q <= '0;
							state_q <= ST_CA_RD;
						end else begin
							state_q <= ST_CT_RD;
						end
					end else if (row_q[sb_q]) begin
						dw_q <= '0;
						state_q <= ST_CO_RD;
					end else begin
						j_q <= j_q + CW'(1);
						if (adv_wrap) begin
							sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_CS_RD;
						end else begin
							sb_q <= sb_q + BW'(1); state_q <= ST_CS_BIT;
						end
					end
				end
				ST_CO_RD: state_q <= ST_CO_WR;
				ST_CO_WR: begin
					if (dw_q == RW'(ROW_WORDS - 1)) begin
						j_q <= j_q + CW'(1);
						if (adv_wrap) begin
							sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_CS_RD;
						end else begin
							sb_q <= sb_q + BW'(1); state_q <= ST_CS_BIT;
						end
					end else begin
						dw_q <= dw_q + RW'(1);
						state_q <= ST_CO_RD;
					end
				end
				ST_CA_RD: state_q <= ST_CA_LD;
				ST_CA_LD: begin
					row_q <= d_rda;
					state_q <= ST_CA_BIT;
				end
				ST_CA_BIT: begin
					if (j_q >= n) begin
						if (i_q + CW'(1) == n) begin
							lhs_q <= '0; rhs_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + CW'(1);
							if (diag_b_q == BW'(WORD_BITS - 1)) begin
								diag_b_q <= '0;
								diag_w_q <= diag_w_q + RW'(1);
							end else begin
								diag_b_q <= diag_b_q + BW'(1);
							end
							wd_q <= '0; sb_q <= '0; j_q <= '0;
							state_q <= ST_CA_RD;
						end
					end else if (row_q[sb_q]) begin
						state_q <= ST_CA_SRD;
					end else begin
						j_q <= j_q + CW'(1);
						if (adv_wrap) begin
							sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_CA_RD;
						end else begin
							sb_q <= sb_q + BW'(1); state_q <= ST_CA_BIT;
						end
					end
				end
				ST_CA_SRD: state_q <= ST_CA_SWR;
				ST_CA_SWR: begin
					j_q <= j_q + CW'(1);
					if (adv_wrap) begin
						sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_CA_RD;
					end else begin
						sb_q <= sb_q + BW'(1); state_q <= ST_CA_BIT;
					end
				end
				ST_F_START: begin
					fa_q <= lhs_q;
					fb_q <= (CW'(rhs_q) <= lhs_q) ? lhs_q + CW'(1) : CW'(rhs_q);
					state_q <= ST_F_PAIR;
				end
				ST_F_PAIR: begin
					if (fa_q >= n) begin
						state_q <= ST_F_EXH;
					end else if (fb_q >= n) begin
						fa_q <= fa_q + CW'(1);
						fb_q <= fa_q + CW'(2);
					end else begin
						wa_q <= f_word(fa_q);
						wb_q <= f_word(fb_q);
						state_q <= ST_F_RD;
					end
				end
				ST_F_RD: begin
					ba_q <= BW'(16'(fa_q) - 16'(wa_q) * 16'(WORD_BITS));
					bb_q <= BW'(16'(fb_q) - 16'(wb_q) * 16'(WORD_BITS));
					state_q <= ST_F_CHK;
				end
				ST_F_CHK: begin
					if (p_rda[bb_q] || p_rdb[ba_q]) begin
						state_q <= ST_F_FOUND;
					end else if (d_rda[bb_q] || d_rdb[ba_q]) begin
						if (d_rda[bb_q]) begin
							ofrom_q <= IW'(fa_q); oto_q <= IW'(fb_q);
							pend_q <= d_rdb[ba_q];
						end else begin
							ofrom_q <= IW'(fb_q); oto_q <= IW'(fa_q);
							pend_q <= 1'b0;
						end
						sum_q <= '0; wd_q <= '0; sb_q <= '0; j_q <= '0;
						state_q <= ST_O_RD;
					end else begin
						fb_q <= fb_q + CW'(1);
						state_q <= ST_F_PAIR;
					end
				end
				ST_O_RD: state_q <= ST_O_LD;
				ST_O_LD: begin
					row_q <= d_rda & an_rd;
					state_q <= ST_O_BIT;
				end
				ST_O_BIT: begin
					if (j_q >= n) begin
						state_q <= ST_O_END;
					end else if (row_q[sb_q]) begin
						state_q <= ST_O_ADD;
					end else begin
						j_q <= j_q + CW'(1);
						if (adv_wrap) begin
							sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_O_RD;
						end else begin
							sb_q <= sb_q + BW'(1); state_q <= ST_O_BIT;
						end
					end
				end
				ST_O_ADD: begin
					sum_q <= sum_q + SUMW'(w_rd);
					j_q <= j_q + CW'(1);
					if (adv_wrap) begin
						sb_q <= '0; wd_q <= wd_q + RW'(1); state_q <= ST_O_RD;
					end else begin
						sb_q <= sb_q + BW'(1); state_q <= ST_O_BIT;
					end
				end
				ST_O_END: begin
					if (CAP_W'(sum_q) > capacity) begin
						state_q <= ST_F_FOUND;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						ofrom_q <= IW'(fb_q); oto_q <= IW'(fa_q);
						sum_q <= '0; wd_q <= '0; sb_q <= '0; j_q <= '0;
						state_q <= ST_O_RD;
					end else begin
						fb_q <= fb_q + CW'(1);
						state_q <= ST_F_PAIR;
					end
				end
				ST_F_FOUND: begin
					if (res_ok) begin
						if (fb_q == CW'(MAX_ITEMS - 1)) begin
							lhs_q <= fa_q + CW'(1);
							rhs_q <= '0;
						end else begin
							lhs_q <= fa_q;
							rhs_q <= IW'(fb_q + CW'(1));
						end
						state_q <= ST_IDLE;
					end
				end
				ST_F_EXH: begin
					if (res_ok) begin
						lhs_q <= CW'(MAX_ITEMS);
						rhs_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pcef_ram #(.ADDR_W(ADDR_W), .DATA_W(WORD_BITS)) u_succ (
		.clk(clk), .we(s_we), .wr_addr(s_wa), .wr_data(s_wd),
		.rd_addr_a(s_ra), .rd_data_a(s_rd), .rd_addr_b('0), .rd_data_b()
	);

	pcef_ram #(.ADDR_W(ADDR_W), .DATA_W(WORD_BITS)) u_sep (
		.clk(clk), .we(p_we), .wr_addr(p_wa), .wr_data(p_wd),
		.rd_addr_a(p_raa), .rd_data_a(p_rda), .rd_addr_b(p_rab), .rd_data_b(p_rdb)
	);

	pcef_ram #(.ADDR_W(ADDR_W), .DATA_W(WORD_BITS)) u_desc (
		.clk(clk), .we(d_we), .wr_addr(d_wa), .wr_data(d_wd),
		.rd_addr_a(d_raa), .rd_data_a(d_rda), .rd_addr_b(d_rab), .rd_data_b(d_rdb)
	);

	pcef_ram #(.ADDR_W(ADDR_W), .DATA_W(WORD_BITS)) u_anc (
		.clk(clk), .we(an_we), .wr_addr(an_wa), .wr_data(an_wd),
		.rd_addr_a(an_ra), .rd_data_a(an_rd), .rd_addr_b('0), .rd_data_b()
	);

	pcef_ram #(.ADDR_W(IW), .DATA_W(WEIGHT_W)) u_wt (
		.clk(clk), .we(w_we), .wr_addr(w_wa), .wr_data(w_wd),
		.rd_addr_a(w_ra), .rd_data_a(w_rd), .rd_addr_b('0), .rd_data_b()
	);

	pcef_ram #(.ADDR_W(IW), .DATA_W(INDEX_W)) u_topo (
		.clk(clk), .we(t_we), .wr_addr(t_wa), .wr_data(t_wd),
		.rd_addr_a(t_ra), .rd_data_a(t_rd), .rd_addr_b('0), .rd_data_b()
	);

endmodule

// File: verif/precedence_conflict_edge_finder_tb.sv
// ----------------------------------------------------------------------------
// precedence_conflict_edge_finder_tb
// Self-checking bench: loads weights, edges, separation marks and orders in
// phases, runs compute and fetch requests through the valid/ready port with
// bursty requests and a stalling result side, and checks every fetched pair
// against a bitset predictor of the closure and the conflict scan.
// ----------------------------------------------------------------------------
module precedence_conflict_edge_finder_tb;
	import pcef_pkg::*;

	localparam int NODES = 256;
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam action_t ACT_SPARE_A = ACT_FETCH + 3'd1;
	localparam action_t ACT_SPARE_B = ACT_FETCH + 3'd2;

	typedef struct {
		action_t act;
		index_t  a;
		index_t  b;
		weight_t w;
	} request_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;
	logic       in_valid;
	logic       in_ready;
	action_t    action;
	index_t     index_a;
	index_t     index_b;
	weight_t    weight;
	logic       out_valid;
	logic       out_ready;
	index_t     first_item;
	index_t     second_item;
	logic       exhausted;

	precedence_conflict_edge_finder u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .index_a(index_a), .index_b(index_b), .weight(weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.first_item(first_item), .second_item(second_item), .exhausted(exhausted)
	);

	// predictor state
	bit [NODES-1:0] succ_rows [NODES];
	bit [NODES-1:0] sep_rows  [NODES];
	bit [NODES-1:0] desc_rows [NODES];
	bit [NODES-1:0] anc_rows  [NODES];
	weight_t        item_wt   [NODES];
	index_t         topo_pos  [NODES];
	int unsigned    scan_pos;
	cap_t           cap_reg;
	int unsigned    count_reg;

	request_t pending_reqs [$];
	res_t     expected_pairs [$];
	int       errors;
	int       cycles;
	int       total_items;
	logic     req_taken;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int unsigned live_items();
		return (count_reg > NODES) ? NODES : count_reg;
	endfunction

	function automatic void build_closure(int unsigned n);
		int unsigned from;
		for (int i = 0; i < NODES; i++) begin
			desc_rows[i] = '0;
			anc_rows[i] = '0;
		end
		for (int i = 0; i < n; i++)
			desc_rows[i][i] = 1'b1;
		for (int k = n; k > 0; k--) begin
			from = topo_pos[k-1];
			if (from < n) begin
				for (int j = 0; j < n; j++)
					if (succ_rows[from][j])
						desc_rows[from] |= desc_rows[j];
			end
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (desc_rows[i][j])
					anc_rows[j][i] = 1'b1;
		scan_pos = 0;
	endfunction

	function automatic bit overloaded(int unsigned f, int unsigned t, int unsigned n);
		longint unsigned load;
		load = 0;
		for (int k = 0; k < n; k++)
			if (desc_rows[f][k] && anc_rows[t][k])
				load += item_wt[k];
		return load > longint'(cap_reg);
	endfunction

	function automatic bit pair_conflicts(int unsigned a, int unsigned b, int unsigned n);
		if (sep_rows[a][b] || sep_rows[b][a])
			return 1'b1;
		if (desc_rows[a][b] && overloaded(a, b, n))
			return 1'b1;
		return desc_rows[b][a] && overloaded(b, a, n);
	endfunction

	function automatic res_t next_pair(int unsigned n);
		res_t r;
		int unsigned lhs;
		int unsigned rhs;
		lhs = scan_pos / NODES;
		rhs = scan_pos % NODES;
		for (; lhs < n; lhs++) begin
			if (rhs <= lhs)
				rhs = lhs + 1;
			for (; rhs < n; rhs++) begin
				if (pair_conflicts(lhs, rhs, n)) begin
					scan_pos = lhs * NODES + rhs + 1;
					r.exhausted = 1'b0;
					r.first_item = index_t'(lhs);
					r.second_item = index_t'(rhs);
					return r;
				end
			end
			rhs = 0;
		end
		scan_pos = NODES * NODES;
		r.exhausted = 1'b1;
		r.first_item = '0;
		r.second_item = '0;
		return r;
	endfunction

	function automatic void apply_request(request_t q);
		int unsigned n;
		n = live_items();
		case (q.act)
			ACT_WEIGHT: item_wt[q.a] = q.w;
			ACT_EDGE: succ_rows[q.a][q.b] = 1'b1;
			ACT_SEP: sep_rows[q.a][q.b] = 1'b1;
			ACT_TOPO: topo_pos[q.a] = q.b;
			ACT_COMPUTE: build_closure(n);
			ACT_FETCH: expected_pairs.push_back(next_pair(n));
			default: ;
		endcase
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result check, then prediction of the request taken at this edge
	always @(posedge clk) begin
		res_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL precedence_conflict_edge_finder");
			$finish;
		end else begin
			if (arst_n && out_valid && out_ready) begin
				if (expected_pairs.size() == 0) begin
					report("unexpected result", exhausted, 0);
				end else begin
					want = expected_pairs.pop_front();
					if (exhausted !== want.exhausted)
						report("exhausted", exhausted, want.exhausted);
					if (first_item !== want.first_item)
						report("first_item", first_item, want.first_item);
					if (second_item !== want.second_item)
						report("second_item", second_item, want.second_item);
				end
			end
			if (arst_n && in_valid && in_ready)
				apply_request('{action, index_a, index_b, weight});
			req_taken <= arst_n && in_valid && in_ready;
		end
	end

	// request driver: bursts with gaps
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		request_t q;
		if (in_valid && !req_taken) begin
			in_valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_reqs.size() > 0) begin
			q = pending_reqs.pop_front();
			action <= q.act;
			index_a <= q.a;
			index_b <= q.b;
			weight <= q.w;
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result side stall pattern
	int stall_mode;
	int stall_span;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_span <= $urandom_range(16, 200);
			stall_mode <= $urandom_range(0, 3);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (cycles % 5) != 0;
		endcase
	end

	task automatic push_req(action_t act, int unsigned a, int unsigned b, int unsigned w);
		pending_reqs.push_back('{act, index_t'(a), index_t'(b), weight_t'(w)});
		total_items++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_pairs.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, cfg_data_t data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_CAPACITY)
			cap_reg = data;
		else
			count_reg = data[COUNT_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int unsigned pick_weight();
		case ($urandom_range(0, 9)) inside
			0, 1: return 0;
			2: return 16'hFFFF;
			3, 4, 5: return $urandom_range(0, 20);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	function automatic int unsigned pick_capacity();
		case ($urandom_range(0, 7)) inside
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			3, 4: return $urandom_range(0, 60);
			default: return $urandom_range(0, 200000);
		endcase
	endfunction

	task automatic load_phase(int unsigned n, int unsigned edge_cnt, int unsigned fetch_cnt);
		int unsigned order [NODES];
		int unsigned p;
		int unsigned t;
		int unsigned tmp;
		for (int i = 0; i < n; i++)
			order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			t = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[t];
			order[t] = tmp;
		end
		for (int i = 0; i < n; i++)
			push_req(ACT_WEIGHT, i, $urandom_range(0, 255), pick_weight());
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < n; i++)
				push_req(ACT_TOPO, i, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF));
		end else begin
			for (int i = 0; i < n; i++)
				push_req(ACT_TOPO, i, order[i], $urandom_range(0, 16'hFFFF));
		end
		for (int e = 0; e < edge_cnt; e++) begin
			if (n > 1 && $urandom_range(0, 9) != 0) begin
				p = $urandom_range(0, n - 2);
				t = $urandom_range(p + 1, n - 1);
				push_req(ACT_EDGE, order[p], order[t], $urandom_range(0, 16'hFFFF));
			end else begin
				push_req(ACT_EDGE, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 16'hFFFF));
			end
		end
		for (int s = $urandom_range(0, 2); s > 0; s--)
			push_req(ACT_SEP, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
				$urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 5) == 0)
			push_req(ACT_SEP, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
		for (int z = $urandom_range(0, 2); z > 0; z--)
			push_req(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 16'hFFFF));
		push_req(ACT_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 16'hFFFF));
		for (int f = 0; f < fetch_cnt; f++) begin
			if ($urandom_range(0, 7) == 0)
				push_req(ACT_SEP, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
			push_req(ACT_FETCH, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 16'hFFFF));
		end
	endtask

	initial begin
		int unsigned n;
		int unsigned n2;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_WEIGHT;
		index_a = '0;
		index_b = '0;
		weight = '0;
		out_ready = 1'b0;
		req_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_span = 0;
		errors = 0;
		cycles = 0;
		total_items = 0;
		cap_reg = '0;
		count_reg = 1;
		scan_pos = 0;
		for (int i = 0; i < NODES; i++) begin
			succ_rows[i] = '0;
			sep_rows[i] = '0;
			desc_rows[i] = '0;
			anc_rows[i] = '0;
			item_wt[i] = '0;
			topo_pos[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every action, spare codes, exhausted repeats
		write_reg(CFG_CAPACITY, 0);
		write_reg(CFG_ITEM_COUNT, 4);
		push_req(ACT_WEIGHT, 0, 0, 16'hFFFF);
		push_req(ACT_WEIGHT, 1, 255, 0);
		push_req(ACT_WEIGHT, 2, 0, 1);
		push_req(ACT_WEIGHT, 3, 0, 7);
		push_req(ACT_TOPO, 0, 0, 0);
		push_req(ACT_TOPO, 1, 1, 0);
		push_req(ACT_TOPO, 2, 2, 0);
		push_req(ACT_TOPO, 3, 3, 0);
		push_req(ACT_EDGE, 0, 1, 0);
		push_req(ACT_EDGE, 1, 2, 0);
		push_req(ACT_EDGE, 255, 255, 16'hFFFF);
		push_req(ACT_SEP, 3, 0, 0);
		push_req(ACT_SEP, 255, 0, 0);
		push_req(ACT_SPARE_A, 255, 255, 16'hFFFF);
		push_req(ACT_SPARE_B, 0, 0, 0);
		push_req(ACT_COMPUTE, 0, 0, 0);
		for (int f = 0; f < 6; f++)
			push_req(ACT_FETCH, 0, 0, 0);
		wait_idle();
		write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
		push_req(ACT_COMPUTE, 0, 0, 0);
		push_req(ACT_FETCH, 0, 0, 0);
		push_req(ACT_FETCH, 0, 0, 0);
		wait_idle();

		// one full-size phase
		write_reg(CFG_ITEM_COUNT, NODES);
		write_reg(CFG_CAPACITY, pick_capacity());
		load_phase(NODES, 12, 1);
		wait_idle();

		while (total_items < 1950) begin
			n = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 12);
			write_reg(CFG_ITEM_COUNT, n);
			write_reg(CFG_CAPACITY, pick_capacity());
			load_phase(n, $urandom_range(0, n + 2), $urandom_range(1, n + 3));
			wait_idle();
			if ($urandom_range(0, 3) == 0) begin
				// item count moved after compute
				if ($urandom_range(0, 1) != 0 || n == 1) begin
					n2 = n + $urandom_range(1, 4);
					write_reg(CFG_ITEM_COUNT, n2);
					for (int i = n; i < n2; i++)
						push_req(ACT_WEIGHT, i, 0, pick_weight());
				end else begin
					write_reg(CFG_ITEM_COUNT, $urandom_range(1, n - 1));
				end
				for (int f = $urandom_range(1, 4); f > 0; f--)
					push_req(ACT_FETCH, 0, 0, 0);
				wait_idle();
			end
		end

		wait_idle();
		if (errors == 0)
			$display("PASS precedence_conflict_edge_finder");
		else
			$display("FAIL precedence_conflict_edge_finder");
		$finish;
	end

endmodule

// File: filelist.f
design/pcef_pkg.sv
design/pcef_ram.sv
design/pcef_ctrl.sv
design/precedence_conflict_edge_finder.sv
verif/precedence_conflict_edge_finder_tb.sv
